FILE: sv/frame_buffer_lock_pool_defines.svh
// ----------------------------------------------------------------------------
// Frame buffer lock pool assertion macros
// Shared helpers for writing the concurrent checks of the lock pool.
// ----------------------------------------------------------------------------
`ifndef FRAME_BUFFER_LOCK_POOL_DEFINES_SVH
`define FRAME_BUFFER_LOCK_POOL_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FLBP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FLBP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/flbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame buffer lock pool package
// Sizes, codes and word types shared by the lock pool modules.
// ----------------------------------------------------------------------------
package flbp_pkg;

   localparam int NUM_FRAMES  = 4;
   localparam int FRAME_IDX_W = $clog2(NUM_FRAMES);

   localparam int CMD_W      = 2;
   localparam int SEQ_W      = 32;
   localparam int FRAME_IN_W = 4;
   localparam int STATUS_W   = 3;
   localparam int CNT_W      = 8;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK           = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_NONE         = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_STOPPED      = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_RELEASE  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_READERS_FULL = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_WLOCK_HELD   = 3'd5;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_CAPTURE_RUNNING = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   typedef enum logic [1:0] {
      UPD_NONE,
      UPD_SEQ_LOCK,
      UPD_LOCK_CLR,
      UPD_CNT
   } upd_op_type;

   typedef struct packed {
      logic [CMD_W-1:0]      cmd;
      logic [SEQ_W-1:0]      seq;
      logic [FRAME_IN_W-1:0] frame_index;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [FRAME_IN_W-1:0] granted_frame;
      logic [SEQ_W-1:0]      granted_seq;
   } rsp_word_type;

   typedef struct packed {
      logic [SEQ_W-1:0] seq;
      logic             wlock;
      logic [CNT_W-1:0] cnt;
   } frame_entry_type;

   typedef struct packed {
      upd_op_type             op;
      logic [FRAME_IDX_W-1:0] idx;
      logic [SEQ_W-1:0]       seq;
      logic [CNT_W-1:0]       cnt;
   } tbl_upd_type;

endpackage

FILE: sv/flbp_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame buffer lock pool compare unit
// One subtractor shared by the write and read scans to qualify a frame.
// ----------------------------------------------------------------------------
module flbp_cmp import flbp_pkg::*; (
   input  logic             is_write,
   input  frame_entry_type  entry,
   input  logic [SEQ_W-1:0] bound,
   output logic             cand
);

   logic [SEQ_W-1:0] op_a;
   logic [SEQ_W-1:0] op_b;
   logic [SEQ_W:0]   diff;
   logic             less;

   // A write looks for entry < bound, a read for bound < entry.
   assign op_a = is_write ? entry.seq : bound;
   assign op_b = is_write ? bound : entry.seq;
   assign diff = {1'b0, op_a} - {1'b0, op_b};
   assign less = diff[SEQ_W];

   always_comb begin
      if (is_write) begin
         cand = less && (entry.cnt == '0);
      end else begin
         cand = less && !entry.wlock;
      end
   end

endmodule

FILE: sv/flbp_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame buffer lock pool table
// Holds sequence number, write lock and reader count of every frame.
// ----------------------------------------------------------------------------
module flbp_table import flbp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  tbl_upd_type            upd,
   input  logic [FRAME_IDX_W-1:0] rd_idx,
   output frame_entry_type        rd_entry,
   output logic                   any_wlock
);

   logic [SEQ_W-1:0]      seq_ff   [NUM_FRAMES];
   logic [NUM_FRAMES-1:0] wlock_ff;
   logic [CNT_W-1:0]      cnt_ff   [NUM_FRAMES];
   logic                  rd_in_range;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_FRAMES; i++) begin
            seq_ff[i] <= '0;
            cnt_ff[i] <= '0;
         end
         wlock_ff <= '0;
      end else begin
         unique case (upd.op)
            UPD_SEQ_LOCK: begin
               seq_ff[upd.idx]   <= upd.seq;
               wlock_ff[upd.idx] <= 1'b1;
            end
            UPD_LOCK_CLR: begin
               wlock_ff[upd.idx] <= 1'b0;
            end
            UPD_CNT: begin
               cnt_ff[upd.idx] <= upd.cnt;
            end
            UPD_NONE: begin
            end
            default: begin
            end
         endcase
      end
   end

   assign rd_in_range = ({1'b0, rd_idx} < (FRAME_IDX_W+1)'(NUM_FRAMES));

   always_comb begin
      if (rd_in_range) begin
         rd_entry.seq   = seq_ff[rd_idx];
         rd_entry.wlock = wlock_ff[rd_idx];
         rd_entry.cnt   = cnt_ff[rd_idx];
      end else begin
         rd_entry = '0;
      end
   end

   assign any_wlock = |wlock_ff;

endmodule

FILE: sv/frame_buffer_lock_pool.sv
`timescale 1ns / 1ps
// Writes and reads scan the frames one at a time in index order through the shared
// compare unit, then commit the result word; releases and unused commands go straight
// to commit. One word is in work at a time, so a new word is accepted only after the
// last one has committed, and the commit waits while a stalled result word is held.
// Synchronous reset clears all frames, locks and counts at once and stops capture.
// ----------------------------------------------------------------------------
// Frame buffer lock pool
// Sequenced scan of the frame table that grants write and read locks.
// ----------------------------------------------------------------------------
module frame_buffer_lock_pool import flbp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_word_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_word_type          rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   state_type              state_ff, state_in;
   logic [CMD_W-1:0]       cmd_ff, cmd_in;
   logic [SEQ_W-1:0]       seq_ff, seq_in;
   logic [FRAME_IN_W-1:0]  idx_ff, idx_in;
   logic [SEQ_W-1:0]       bound_ff, bound_in;
   logic                   found_ff, found_in;
   logic [FRAME_IDX_W-1:0] pick_ff, pick_in;
   logic [CNT_W-1:0]       pick_cnt_ff, pick_cnt_in;
   logic [FRAME_IDX_W-1:0] scan_idx_ff, scan_idx_in;
   logic                   running_ff, running_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_word_type           rsp_ff, rsp_in;

   logic                   req_fire;
   logic                   rsp_free;
   logic                   commit_go;
   logic                   scan_last;
   logic                   is_write;
   logic                   idx_in_range;
   logic                   cand;
   logic                   any_wlock;
   logic                   csr_wr;
   logic [FRAME_IDX_W-1:0] rd_idx;
   frame_entry_type        rd_entry;
   tbl_upd_type            upd_raw;
   tbl_upd_type            upd;
   rsp_word_type           result;

   flbp_table u_table (
      .clock     (clock),
      .reset     (reset),
      .upd       (upd),
      .rd_idx    (rd_idx),
      .rd_entry  (rd_entry),
      .any_wlock (any_wlock)
   );

   flbp_cmp u_cmp (
      .is_write (is_write),
      .entry    (rd_entry),
      .bound    (bound_ff),
      .cand     (cand)
   );

   assign req_fire     = req_valid && !req_stall;
   assign rsp_free     = !rsp_valid_ff || !rsp_stall;
   assign commit_go    = (state_ff == ST_COMMIT) && rsp_free;
   assign scan_last    = (scan_idx_ff == FRAME_IDX_W'(NUM_FRAMES - 1));
   assign is_write     = (cmd_ff == CMD_WRITE);
   assign idx_in_range = ({1'b0, idx_ff} < (FRAME_IN_W+1)'(NUM_FRAMES));
   assign csr_wr       = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.cmd == CMD_WRITE || req_data.cmd == CMD_READ) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_COMMIT;
               end
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer: table port and commit decision
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      rd_idx    = (state_ff == ST_SCAN) ? scan_idx_ff : idx_ff[FRAME_IDX_W-1:0];
      result    = '{status: STATUS_OK, granted_frame: '0, granted_seq: '0};
      upd_raw   = '{op: UPD_NONE, idx: '0, seq: '0, cnt: '0};
      unique case (cmd_ff)
         CMD_WRITE: begin
            if (any_wlock) begin
               result.status = STATUS_WLOCK_HELD;
            end else if (!found_ff) begin
               result.status = STATUS_NONE;
            end else begin
               result.granted_frame = FRAME_IN_W'(pick_ff);
               result.granted_seq   = seq_ff;
               upd_raw.op  = UPD_SEQ_LOCK;
               upd_raw.idx = pick_ff;
               upd_raw.seq = seq_ff;
            end
         end
         CMD_READ: begin
            if (!running_ff) begin
               result.status = STATUS_STOPPED;
            end else if (!found_ff) begin
               result.status = STATUS_NONE;
            end else if (pick_cnt_ff == CNT_MAX) begin
               result.status = STATUS_READERS_FULL;
            end else begin
               result.granted_frame = FRAME_IN_W'(pick_ff);
               result.granted_seq   = bound_ff;
               upd_raw.op  = UPD_CNT;
               upd_raw.idx = pick_ff;
               upd_raw.cnt = pick_cnt_ff + CNT_W'(1);
            end
         end
         CMD_RELEASE: begin
            // A write lock is dropped first, whatever the reader count is.
            if (!idx_in_range) begin
               result.status = STATUS_BAD_RELEASE;
            end else if (rd_entry.wlock) begin
               upd_raw.op  = UPD_LOCK_CLR;
               upd_raw.idx = idx_ff[FRAME_IDX_W-1:0];
            end else if (rd_entry.cnt != '0) begin
               upd_raw.op  = UPD_CNT;
               upd_raw.idx = idx_ff[FRAME_IDX_W-1:0];
               upd_raw.cnt = rd_entry.cnt - CNT_W'(1);
            end else begin
               result.status = STATUS_BAD_RELEASE;
            end
         end
         default: begin
         end
      endcase
      upd = upd_raw;
      if (!commit_go) begin
         upd.op = UPD_NONE;
      end
   end

   // Datapath next values
   always_comb begin
      cmd_in       = cmd_ff;
      seq_in       = seq_ff;
      idx_in       = idx_ff;
      bound_in     = bound_ff;
      found_in     = found_ff;
      pick_in      = pick_ff;
      pick_cnt_in  = pick_cnt_ff;
      scan_idx_in  = scan_idx_ff;
      running_in   = running_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (req_fire) begin
         cmd_in      = req_data.cmd;
         seq_in      = req_data.seq;
         idx_in      = req_data.frame_index;
         bound_in    = req_data.seq;
         found_in    = 1'b0;
         scan_idx_in = '0;
      end

      // Strict compare keeps the lowest index among equal numbers.
      if (state_ff == ST_SCAN) begin
         scan_idx_in = scan_idx_ff + FRAME_IDX_W'(1);
         if (cand) begin
            bound_in    = rd_entry.seq;
            found_in    = 1'b1;
            pick_in     = scan_idx_ff;
            pick_cnt_in = rd_entry.cnt;
         end
      end

      if (commit_go) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_wr && csr_paddr[CSR_ADDR_W-1] == REG_CAPTURE_RUNNING) begin
         running_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         running_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         running_ff   <= running_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      seq_ff      <= seq_in;
      idx_ff      <= idx_in;
      bound_ff    <= bound_in;
      found_ff    <= found_in;
      pick_ff     <= pick_in;
      pick_cnt_ff <= pick_cnt_in;
      scan_idx_ff <= scan_idx_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == REG_CAPTURE_RUNNING) ?
                       {{(CSR_DATA_W-1){1'b0}}, running_ff} : '0;

endmodule

FILE: sv/flbp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame buffer lock pool checker
// Port-level checks of the lock pool, bound to the top level.
// ----------------------------------------------------------------------------
`include "frame_buffer_lock_pool_defines.svh"

module flbp_checker import flbp_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input req_word_type          req_data,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input rsp_word_type          rsp_data,
   input logic                  csr_psel,
   input logic                  csr_penable,
   input logic                  csr_pwrite,
   input logic [CSR_ADDR_W-1:0] csr_paddr,
   input logic [CSR_DATA_W-1:0] csr_pwdata,
   input logic [CSR_DATA_W-1:0] csr_prdata,
   input logic                  csr_pready
);

   `FLBP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "result word dropped while stalled")
   `FLBP_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_data), "stalled result word changed")
   `FLBP_ASSERT_NEXT(a_one_in_work, clock, reset, req_valid && !req_stall, req_stall, "second word accepted while one is in work")
   `FLBP_ASSERT_SAME(a_refused_zero, clock, reset, rsp_valid && rsp_data.status != STATUS_OK, rsp_data.granted_frame == '0 && rsp_data.granted_seq == '0, "refused request carries a grant")
   `FLBP_ASSERT_SAME(a_frame_range, clock, reset, rsp_valid, rsp_data.granted_frame <= FRAME_IN_W'(NUM_FRAMES - 1), "granted frame outside the pool")

endmodule

bind frame_buffer_lock_pool flbp_checker u_flbp_checker (.*);

FILE: test/frame_buffer_lock_pool_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame buffer lock pool testbench
// Drives write, read, release and unused commands through the request channel and
// checks every result word against a predictor of the frame table. Both sides
// idle and stall at random, and capture is switched on and off between phases.
// ----------------------------------------------------------------------------
module frame_buffer_lock_pool_tb;
   import flbp_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] CAPTURE_ADDR = CSR_ADDR_W'(4 * REG_CAPTURE_RUNNING);
   localparam int SETTLE_CYCLES = 12;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_word_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_word_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   // Predicted frame table and capture setting.
   logic [SEQ_W-1:0] frame_seq [NUM_FRAMES] = '{default: '0};
   logic [NUM_FRAMES-1:0] write_lock = '0;
   logic [CNT_W-1:0] reader_cnt [NUM_FRAMES] = '{default: '0};
   logic capture_running = 1'b0;

   rsp_word_type grant_q [$];
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   int unsigned hold_len = 0;
   int unsigned hold_token = 0;
   int unsigned hold_seen = 0;
   int unsigned hold_left = 0;
   logic [SEQ_W-1:0] write_seq_next = 32'd16;

   frame_buffer_lock_pool i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Result side stall: a requested hold-off takes precedence over random stalls.
   always @(posedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen <= hold_token;
         hold_left <= hold_len;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Inputs change only at rising edges, so the values seen at the falling edge
   // are the ones sampled at the next rising edge.
   always @(negedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (grant_q.size() == 0) begin
            report_mismatch("unexpected result word", 32'(rsp_data.status), 32'd0);
         end else begin
            want = grant_q.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
            if (rsp_data.granted_frame !== want.granted_frame)
               report_mismatch("granted_frame", 32'(rsp_data.granted_frame),
                               32'(want.granted_frame));
            if (rsp_data.granted_seq !== want.granted_seq)
               report_mismatch("granted_seq", rsp_data.granted_seq, want.granted_seq);
         end
      end
   end

   function automatic rsp_word_type predict_grant(input req_word_type w);
      rsp_word_type r;
      int pick;
      int idx;
      logic [SEQ_W-1:0] bound;
      r = '0;
      r.status = STATUS_OK;
      pick = -1;
      bound = w.seq;
      idx = w.frame_index;
      case (w.cmd)
         CMD_WRITE: begin
            if (|write_lock) begin
               r.status = STATUS_WLOCK_HELD;
            end else begin
               // Strict compare keeps the lowest index among equal numbers.
               for (int i = 0; i < NUM_FRAMES; i++) begin
                  if (reader_cnt[i] == 0 && frame_seq[i] < bound) begin
                     pick = i;
                     bound = frame_seq[i];
                  end
               end
               if (pick < 0) begin
                  r.status = STATUS_NONE;
               end else begin
                  write_lock[pick] = 1'b1;
                  frame_seq[pick] = w.seq;
                  r.granted_frame = FRAME_IN_W'(pick);
                  r.granted_seq = w.seq;
               end
            end
         end
         CMD_READ: begin
            if (!capture_running) begin
               r.status = STATUS_STOPPED;
            end else begin
               for (int i = 0; i < NUM_FRAMES; i++) begin
                  if (!write_lock[i] && frame_seq[i] > bound) begin
                     pick = i;
                     bound = frame_seq[i];
                  end
               end
               if (pick < 0) begin
                  r.status = STATUS_NONE;
               end else if (reader_cnt[pick] == CNT_MAX) begin
                  r.status = STATUS_READERS_FULL;
               end else begin
                  reader_cnt[pick] = reader_cnt[pick] + CNT_W'(1);
                  r.granted_frame = FRAME_IN_W'(pick);
                  r.granted_seq = frame_seq[pick];
               end
            end
         end
         CMD_RELEASE: begin
            if (idx >= NUM_FRAMES)
               r.status = STATUS_BAD_RELEASE;
            else if (write_lock[idx])
               write_lock[idx] = 1'b0;
            else if (reader_cnt[idx] != 0)
               reader_cnt[idx] = reader_cnt[idx] - CNT_W'(1);
            else
               r.status = STATUS_BAD_RELEASE;
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic req_word_type make_word(input logic [CMD_W-1:0] cmd,
                                              input logic [SEQ_W-1:0] seq,
                                              input logic [FRAME_IN_W-1:0] frame);
      req_word_type w;
      w.cmd = cmd;
      w.seq = seq;
      w.frame_index = frame;
      return w;
   endfunction

   // Mostly a well-behaved camera: rising write numbers, reads near the newest
   // frame and releases of frames that are actually held.
   function automatic req_word_type next_request();
      req_word_type w;
      int unsigned pick;
      int unsigned sub;
      int held;
      w.frame_index = FRAME_IN_W'($urandom_range(15));
      w.seq = $urandom();
      pick = $urandom_range(99);
      sub = $urandom_range(99);
      held = -1;
      if (pick < 30) begin
         w.cmd = CMD_WRITE;
         if (sub < 85) begin
            write_seq_next = write_seq_next + $urandom_range(1, 4);
            w.seq = write_seq_next;
         end else if (sub < 95) begin
            if (write_seq_next < 32'h8000_0000)
               write_seq_next = write_seq_next + $urandom_range(1, 1 << 28);
            w.seq = write_seq_next;
         end else begin
            w.seq = '0;
         end
      end else if (pick < 62) begin
         w.cmd = CMD_READ;
         if (sub < 55)
            w.seq = write_seq_next - $urandom_range(0, 8);
         else if (sub < 75)
            w.seq = '0;
         else if (sub < 95)
            w.seq = $urandom();
         else
            w.seq = '1;
      end else if (pick < 95) begin
         w.cmd = CMD_RELEASE;
         if (sub < 75) begin
            for (int i = 0; i < NUM_FRAMES; i++)
               if (write_lock[i])
                  held = i;
            if (held < 0) begin
               for (int i = 0; i < NUM_FRAMES; i++)
                  if (reader_cnt[i] != 0 && (held < 0 || $urandom_range(1) == 1))
                     held = i;
            end
            if (held < 0)
               held = $urandom_range(NUM_FRAMES - 1);
            w.frame_index = FRAME_IN_W'(held);
         end
      end else begin
         w.cmd = CMD_UNUSED;
      end
      return w;
   endfunction

   // Called at a rising edge; returns at the edge that accepts the word, with
   // valid left high so that the next word can follow without a bubble.
   task automatic offer_request(input req_word_type w);
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(negedge clock);
      while (req_stall)
         @(negedge clock);
      @(posedge clock);
      grant_q.push_back(predict_grant(w));
   endtask

   task automatic wait_pool_idle();
      req_valid <= 1'b0;
      while (grant_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic check_capture_reg();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      csr_paddr <= CAPTURE_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      while (!csr_pready)
         @(negedge clock);
      if (csr_prdata !== CSR_DATA_W'(capture_running))
         report_mismatch("capture_running read", csr_prdata, CSR_DATA_W'(capture_running));
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Only called while the pool is idle.
   task automatic set_capture(input logic running);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= CAPTURE_ADDR;
      csr_pwdata <= CSR_DATA_W'(running);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      while (!csr_pready)
         @(negedge clock);
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      capture_running = running;
      check_capture_reg();
   endtask

   task automatic test_reset_state();
      check_capture_reg();
      offer_request(make_word(CMD_READ, 32'd10, 4'd0));
      offer_request(make_word(CMD_WRITE, 32'd0, 4'd15));
      offer_request(make_word(CMD_WRITE, 32'd5, 4'd0));
      offer_request(make_word(CMD_WRITE, 32'd9, 4'd0));
      offer_request(make_word(CMD_RELEASE, 32'd0, 4'd0));
      offer_request(make_word(CMD_RELEASE, 32'd0, 4'd0));
      offer_request(make_word(CMD_RELEASE, 32'd0, 4'd15));
      offer_request(make_word(CMD_RELEASE, 32'd0, 4'd4));
      offer_request(make_word(CMD_UNUSED, 32'hFFFF_FFFF, 4'd15));
      wait_pool_idle();
   endtask

   task automatic test_ties_and_skips();
      set_capture(1'b1);
      offer_request(make_word(CMD_WRITE, 32'd7, 4'd0));
      offer_request(make_word(CMD_RELEASE, 32'd0, 4'd1));
      offer_request(make_word(CMD_WRITE, 32'd7, 4'd0));
      offer_request(make_word(CMD_RELEASE, 32'd0, 4'd2));
      offer_request(make_word(CMD_READ, 32'd3, 4'd0));
      offer_request(make_word(CMD_WRITE, 32'd8, 4'd0));
      // The newest frame is locked for writing here, so the read falls back.
      offer_request(make_word(CMD_READ, 32'd3, 4'd0));
      offer_request(make_word(CMD_RELEASE, 32'd0, 4'd3));
      offer_request(make_word(CMD_READ, 32'd7, 4'd0));
      offer_request(make_word(CMD_WRITE, 32'd9, 4'd0));
      offer_request(make_word(CMD_RELEASE, 32'd0, 4'd0));
      offer_request(make_word(CMD_RELEASE, 32'd0, 4'd1));
      offer_request(make_word(CMD_RELEASE, 32'd0, 4'd1));
      offer_request(make_word(CMD_RELEASE, 32'd0, 4'd3));
      wait_pool_idle();
   endtask

   task automatic test_reader_count_full();
      int full_idx;
      full_idx = 0;
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      repeat (CNT_MAX + 1)
         offer_request(make_word(CMD_READ, 32'd0, 4'd0));
      for (int i = 0; i < NUM_FRAMES; i++)
         if (reader_cnt[i] == CNT_MAX)
            full_idx = i;
      // One reader leaves, and the freed place is taken again.
      offer_request(make_word(CMD_RELEASE, 32'd0, FRAME_IN_W'(full_idx)));
      offer_request(make_word(CMD_READ, 32'd0, 4'd0));
      wait_pool_idle();
   endtask

   task automatic test_backpressure();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_len = 150;
      hold_token++;
      repeat (30)
         offer_request(next_request());
      wait_pool_idle();
   endtask

   task automatic test_random_traffic();
      int unsigned req_pct [3] = '{25, 64, 0};
      int unsigned rsp_pct [3] = '{64, 25, 0};
      for (int phase = 0; phase < 3; phase++) begin
         req_idle_pct = req_pct[phase];
         rsp_idle_pct = rsp_pct[phase];
         set_capture(1'b0);
         repeat (20)
            offer_request(next_request());
         wait_pool_idle();
         set_capture(1'b1);
         for (int n = 0; n < 50; n++) begin
            // Now and then the sender waits for every pending result.
            if (n % 20 == 19)
               wait_pool_idle();
            offer_request(next_request());
         end
         wait_pool_idle();
      end
   endtask

   task automatic test_seq_extremes();
      req_idle_pct = 10;
      rsp_idle_pct = 10;
      offer_request(make_word(CMD_WRITE, 32'hFFFF_FFFF, 4'd0));
      offer_request(make_word(CMD_RELEASE, 32'd0, 4'd0));
      for (int i = 0; i < NUM_FRAMES; i++)
         if (frame_seq[i] == 32'hFFFF_FFFF && !write_lock[i] && reader_cnt[i] == 0)
            offer_request(make_word(CMD_RELEASE, 32'd0, FRAME_IN_W'(i)));
      offer_request(make_word(CMD_READ, 32'hFFFF_FFFF, 4'd0));
      offer_request(make_word(CMD_READ, 32'hFFFF_FFFE, 4'd0));
      offer_request(make_word(CMD_WRITE, 32'hFFFF_FFFF, 4'd0));
      wait_pool_idle();
      set_capture(1'b0);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      req_idle_pct = 10;
      rsp_idle_pct = 10;
      test_reset_state();
      test_ties_and_skips();
      test_reader_count_full();
      test_backpressure();
      test_random_traffic();
      test_seq_extremes();
      wait_pool_idle();
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+sv
sv/flbp_pkg.sv
sv/flbp_cmp.sv
sv/flbp_table.sv
sv/frame_buffer_lock_pool.sv
sv/flbp_checker.sv
test/frame_buffer_lock_pool_tb.sv
